// File: design/b58e_pkg.sv
// Shared widths, character constants and digit-to-letter mapping for the base58 encoder.
`default_nettype none
package b58e_pkg;

    localparam int DIGIT_W   = 6;    // one base-58 digit
    localparam int CARRY_W   = 9;    // running carry of the multiply-add pass
    localparam int BYTE_W    = 8;
    localparam int CHAR_W    = 7;
    localparam int RADIX     = 58;
    localparam int RESULT_CAP = 64;  // most characters sent for one message
    localparam int COUNT_W   = 7;    // holds 0 .. RESULT_CAP

    localparam logic [CHAR_W-1:0] CHAR_ONE = 7'd49;   // '1'
    localparam logic [CHAR_W-1:0] CHAR_MAX = 7'd122;  // 'z'

    // Bitcoin alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z
    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] code;
        dx = {1'b0, d};
        priority if (d < 6'd9) begin
            code = 7'd49 + dx;
        end else if (d < 6'd17) begin
            code = 7'd65 + dx - 7'd9;
        end else if (d < 6'd22) begin
            code = 7'd74 + dx - 7'd17;
        end else if (d < 6'd33) begin
            code = 7'd80 + dx - 7'd22;
        end else if (d < 6'd44) begin
            code = 7'd97 + dx - 7'd33;
        end else if (d < 6'd58) begin
            code = 7'd109 + dx - 7'd44;
        end else begin
            code = CHAR_ONE;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// File: design/b58e_digit_ram.sv
// Digit store: single write port, single registered read port.
`default_nettype none
module b58e_digit_ram #(
    parameter int DEPTH = 45,
    parameter int AW    = 6
) (
    input  wire                          aclk,
    input  wire                          we,
    input  wire  [AW-1:0]                waddr,
    input  wire  [b58e_pkg::DIGIT_W-1:0] wdata,
    input  wire                          re,
    input  wire  [AW-1:0]                raddr,
    output logic [b58e_pkg::DIGIT_W-1:0] rdata
);
    import b58e_pkg::*;

    logic [DIGIT_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/b58e_mac.sv
// One digit step of the fold: (256*digit + carry) split into new digit and new carry.
`default_nettype none
module b58e_mac (
    input  wire  [b58e_pkg::DIGIT_W-1:0] digit_in,
    input  wire  [b58e_pkg::CARRY_W-1:0] carry_in,
    output logic [b58e_pkg::DIGIT_W-1:0] digit_out,
    output logic [b58e_pkg::CARRY_W-1:0] carry_out
);
    import b58e_pkg::*;

    // 256*d = 58*(4*d) + 24*d, so only 24*d + carry needs a divide by 58
    logic [10:0] part;
    logic [20:0] prod;
    logic [5:0]  quot;
    logic [10:0] rem;

    always_comb begin
        part = 11'({digit_in, 4'b0000}) + 11'({digit_in, 3'b000}) + 11'(carry_in);
        // 565/32768 is 1/58 with a tiny excess; exact for any 11-bit part
        prod = 21'(part) * 21'd565;
        quot = prod[20:15];
        rem  = part - 11'(quot) * 11'(RADIX);
        digit_out = rem[DIGIT_W-1:0];
        carry_out = CARRY_W'({digit_in, 2'b00}) + CARRY_W'(quot);
    end

endmodule
`default_nettype wire

// File: design/base58_encoder_core.sv
// Top level of the streaming base58 encoder.
// Bytes enter one per beat on s_; the beat with s_last_byte ends a message. Leading
// zero bytes are only counted and bytes past MAX_BYTES are dropped. Every other byte
// runs a multiply-add carry pass over the whole digit memory, one digit per cycle
// through its single read and write port. After the last byte, characters leave on
// m_ at one per cycle for the leading '1's, and the significant digits follow, each
// read and then sent and cleared, as m_ready allows; the memory is cleared behind
// the read. After reset the block zeroes the memory with s_ready low.
`default_nettype none
module base58_encoder_core #(
    parameter int MAX_BYTES  = 32,
    parameter int MAX_DIGITS = 45
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [b58e_pkg::BYTE_W-1:0]   s_data_byte,
    input  wire                           s_last_byte,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [b58e_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_last_char,
    output logic                          m_overflow
);
    import b58e_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_DIGITS - 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_FOLD  = 7'b0000100,
        ST_ZEROS = 7'b0001000,
        ST_DRD   = 7'b0010000,
        ST_DDATA = 7'b0100000,
        ST_WIPE  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       k_reg, k_next;
    logic [CARRY_W-1:0]  carry_reg, carry_next;
    logic [CW-1:0]       zc_reg, zc_next;
    logic                seen_reg, seen_next;
    logic [CW-1:0]       bc_reg, bc_next;
    logic                ovf_reg, ovf_next;
    logic                nz_reg, nz_next;
    logic [AW-1:0]       top_reg, top_next;
    logic                last_pend_reg, last_pend_next;
    logic [CW-1:0]       zrem_reg, zrem_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;
    logic                movf_reg;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [DIGIT_W-1:0]  ram_wdata, ram_rdata;
    logic [DIGIT_W-1:0]  mac_digit;
    logic [CARRY_W-1:0]  mac_carry;

    logic                out_free;
    logic                emit;
    logic [CHAR_W-1:0]   emit_char;
    logic                emit_last;
    logic                go_emit;
    logic                finish;
    logic                capped;

    b58e_digit_ram #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    b58e_mac u_mac (
        .digit_in  (ram_rdata),
        .carry_in  (carry_reg),
        .digit_out (mac_digit),
        .carry_out (mac_carry)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        zc_next        = zc_reg;
        seen_next      = seen_reg;
        bc_next        = bc_reg;
        ovf_next       = ovf_reg;
        nz_next        = nz_reg;
        top_next       = top_reg;
        last_pend_next = last_pend_reg;
        zrem_next      = zrem_reg;
        n_next         = n_reg;
        ram_we         = 1'b0;
        ram_waddr      = k_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = k_reg;
        emit           = 1'b0;
        emit_char      = CHAR_ONE;
        emit_last      = 1'b0;
        go_emit        = 1'b0;
        finish         = 1'b0;
        capped         = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (k_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (bc_reg < CW'(MAX_BYTES)) begin
                        bc_next = bc_reg + CW'(1);
                        if (!seen_reg && s_data_byte == '0) begin
                            zc_next = zc_reg + CW'(1);
                            go_emit = s_last_byte;
                        end else begin
                            // start a fold pass at the least significant digit
                            seen_next      = 1'b1;
                            carry_next     = CARRY_W'(s_data_byte);
                            k_next         = '0;
                            ram_re         = 1'b1;
                            ram_raddr      = '0;
                            nz_next        = 1'b0;
                            last_pend_next = s_last_byte;
                            state_next     = ST_FOLD;
                        end
                    end else begin
                        // drop the byte
                        ovf_next = 1'b1;
                        go_emit  = s_last_byte;
                    end
                end
            end
            ST_FOLD: begin
                ram_we     = 1'b1;
                ram_wdata  = mac_digit;
                carry_next = mac_carry;
                if (mac_digit != '0) begin
                    nz_next  = 1'b1;
                    top_next = k_reg;
                end
                if (k_reg == LAST_IDX) begin
                    if (last_pend_reg) begin
                        go_emit = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    k_next    = k_reg + AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = k_reg + AW'(1);
                end
            end
            ST_ZEROS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = CHAR_ONE;
                    emit_last = (zrem_reg == CW'(1)) && !nz_reg;
                    n_next    = n_reg + COUNT_W'(1);
                    zrem_next = zrem_reg - CW'(1);
                    if (zrem_reg == CW'(1)) begin
                        if (nz_reg) begin
                            state_next = ST_DRD;
                            k_next     = top_reg;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                end
            end
            ST_DRD: begin
                ram_re     = 1'b1;
                state_next = ST_DDATA;
            end
            ST_DDATA: begin
                if (out_free) begin
                    capped    = (n_reg == COUNT_W'(RESULT_CAP - 1));
                    emit      = 1'b1;
                    emit_char = char_of(ram_rdata);
                    emit_last = (k_reg == '0) || capped;
                    ram_we    = 1'b1;
                    n_next    = n_reg + COUNT_W'(1);
                    if (k_reg == '0) begin
                        finish = 1'b1;
                    end else begin
                        k_next     = k_reg - AW'(1);
                        state_next = capped ? ST_WIPE : ST_DRD;
                    end
                end
            end
            ST_WIPE: begin
                // past the result cap: clear the rest without sending
                ram_we = 1'b1;
                if (k_reg == '0) begin
                    finish = 1'b1;
                end else begin
                    k_next = k_reg - AW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (go_emit) begin
            zrem_next = (zc_next == '0 && !nz_next) ? CW'(1) : zc_next;
            n_next    = '0;
            if (zrem_next != '0) begin
                state_next = ST_ZEROS;
            end else begin
                state_next = ST_DRD;
                k_next     = top_next;
            end
        end

        if (finish) begin
            state_next = ST_IDLE;
            zc_next    = '0;
            seen_next  = 1'b0;
            bc_next    = '0;
            ovf_next   = 1'b0;
            nz_next    = 1'b0;
            top_next   = '0;
        end

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            k_reg         <= '0;
            zc_reg        <= '0;
            seen_reg      <= 1'b0;
            bc_reg        <= '0;
            ovf_reg       <= 1'b0;
            nz_reg        <= 1'b0;
            top_reg       <= '0;
            last_pend_reg <= 1'b0;
            zrem_reg      <= '0;
            n_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            zc_reg        <= zc_next;
            seen_reg      <= seen_next;
            bc_reg        <= bc_next;
            ovf_reg       <= ovf_next;
            nz_reg        <= nz_next;
            top_reg       <= top_next;
            last_pend_reg <= last_pend_next;
            zrem_reg      <= zrem_next;
            n_reg         <= n_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg <= carry_next;
        if (emit) begin
            char_reg <= emit_char;
            last_reg <= emit_last;
            movf_reg <= ovf_reg;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last_char = last_reg;
    assign m_overflow  = movf_reg;

endmodule
`default_nettype wire

// File: design/b58e_checker.sv
// Port-level checks for the base58 encoder, bound to the top level.
`default_nettype none
module b58e_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         s_valid,
    input wire                         s_ready,
    input wire [b58e_pkg::BYTE_W-1:0]  s_data_byte,
    input wire                         s_last_byte,
    input wire                         m_valid,
    input wire                         m_ready,
    input wire [b58e_pkg::CHAR_W-1:0]  m_char_code,
    input wire                         m_last_char,
    input wire                         m_overflow
);
    import b58e_pkg::*;

    logic in_msg_reg;
    logic ovf_seen_reg;

    // track the overflow flag of the message whose beats are under way
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg   <= 1'b0;
            ovf_seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            in_msg_reg   <= !m_last_char;
            ovf_seen_reg <= m_overflow;
        end
    end

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data_byte) && $stable(s_last_byte))
        else $error("input beat changed while stalled");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_code) && $stable(m_last_char)
            && $stable(m_overflow))
        else $error("result beat changed while stalled");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_code >= CHAR_ONE) && (m_char_code <= CHAR_MAX))
        else $error("character outside the alphabet range");

    a_ovf_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && in_msg_reg |-> m_overflow == ovf_seen_reg)
        else $error("overflow flag changed within one message");

    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready && !m_valid)
        else $error("ports active right after reset");

endmodule

bind base58_encoder_core b58e_checker u_b58e_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data_byte (s_data_byte),
    .s_last_byte (s_last_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_char_code (m_char_code),
    .m_last_char (m_last_char),
    .m_overflow  (m_overflow)
);
`default_nettype wire
